// ===== sv/lsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types, constants and table functions of the LMS sine fit with PLL.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int Q_W              = IDX_W - 2;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // rounded-up 2^64 reciprocals of the Taylor divisors (2n)(2n+1)
  localparam logic [127:0] TWO_P64 = 128'd1 << 64;
  localparam logic [63:0]  RCP_6   = 64'((TWO_P64 + 128'd5) / 128'd6);
  localparam logic [63:0]  RCP_20  = 64'((TWO_P64 + 128'd19) / 128'd20);
  localparam logic [63:0]  RCP_42  = 64'((TWO_P64 + 128'd41) / 128'd42);
  localparam logic [63:0]  RCP_72  = 64'((TWO_P64 + 128'd71) / 128'd72);
  localparam logic [63:0]  RCP_110 = 64'((TWO_P64 + 128'd109) / 128'd110);
  localparam logic [63:0]  RCP_156 = 64'((TWO_P64 + 128'd155) / 128'd156);
  localparam logic [63:0]  RCP_210 = 64'((TWO_P64 + 128'd209) / 128'd210);

  localparam logic [2:0] REG_TRACK_MODE = 3'd0;
  localparam logic [2:0] REG_BASE_STEP  = 3'd1;
  localparam logic [2:0] REG_STEP_SIZE  = 3'd2;
  localparam logic [2:0] REG_PROP_GAIN  = 3'd3;
  localparam logic [2:0] REG_INTEG_COEF = 3'd4;
  localparam logic [2:0] REG_CORR_GAIN  = 3'd5;

  localparam logic [23:0] PROP_GAIN_RST = 24'd983040;
  localparam logic [31:0] AMP_LIM       = 32'h7FFF_FFFF;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CORR, OP_PHASE, OP_LOOK, OP_MS, OP_MC, OP_ERR,
    OP_EMU, OP_ES, OP_EC, OP_TSMU, OP_TCMU, OP_UPDC, OP_PII, OP_PIP,
    OP_PIO, OP_SQS, OP_SQC, OP_SQSUM, OP_ROOT, OP_DONE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic track_mode;
    logic out_free;
  } status_t;

  typedef logic [QUARTER:0][15:0] qtab_t;

  function automatic qtab_t build_qtab();
    qtab_t        tab;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  r;
    logic [63:0]  rcp;
    logic [127:0] prod;
    for (int k = 0; k <= QUARTER; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / QUARTER;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        case (n)
          1: rcp = RCP_6;
          2: rcp = RCP_20;
          3: rcp = RCP_42;
          4: rcp = RCP_72;
          5: rcp = RCP_110;
          6: rcp = RCP_156;
          default: rcp = RCP_210;
        endcase
        prod = 128'((term * x2) >> 30) * 128'(rcp);
        term = prod[127:64];
        if (n[0]) sum = sum - term;
        else sum = sum + term;
      end
      r = (sum + 64'd16384) >> 15;
      tab[k] = (r > 64'd32767) ? 16'd32767 : r[15:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  function automatic logic signed [15:0] sine_at(input logic [IDX_W-1:0] i);
    logic [1:0]     quad;
    logic [Q_W:0]   r;
    logic [Q_W:0]   rm;
    logic [15:0]    v;
    quad = i[IDX_W-1:IDX_W-2];
    r    = {1'b0, i[Q_W-1:0]};
    rm   = (Q_W+1)'(QUARTER) - r;
    case (quad)
      2'd0: v = QTAB[r];
      2'd1: v = QTAB[rm];
      2'd2: v = 16'd0 - QTAB[r];
      default: v = 16'd0 - QTAB[rm];
    endcase
    return $signed(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] res;
    if (v > 68'sh0_0000_0000_7FFF_FFFF) res = 32'sh7FFF_FFFF;
    else if (v < 68'shF_FFFF_FFFF_8000_0000) res = 32'sh8000_0000;
    else res = v[31:0];
    return res;
  endfunction

endpackage

// ===== sv/lsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_ctrl
// Sequencer: steps the datapath through one sample's update.
// ----------------------------------------------------------------------------
module lsp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lsp_pkg::status_t status_i,
  output lsp_pkg::cmd_t    cmd_o
);

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001, S_CORR  = 21'h000002, S_PHASE = 21'h000004,
    S_LOOK  = 21'h000008, S_MS    = 21'h000010, S_MC    = 21'h000020,
    S_ERR   = 21'h000040, S_EMU   = 21'h000080, S_ES    = 21'h000100,
    S_EC    = 21'h000200, S_TSMU  = 21'h000400, S_TCMU  = 21'h000800,
    S_UPDC  = 21'h001000, S_PII   = 21'h002000, S_PIP   = 21'h004000,
    S_PIO   = 21'h008000, S_SQS   = 21'h010000, S_SQC   = 21'h020000,
    S_SQSUM = 21'h040000, S_ROOT  = 21'h080000, S_DONE  = 21'h100000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = lsp_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = lsp_pkg::OP_LOAD;
          state_d  = S_CORR;
        end
      end
      S_CORR:  begin cmd_o.op = lsp_pkg::OP_CORR;  state_d = S_PHASE; end
      S_PHASE: begin cmd_o.op = lsp_pkg::OP_PHASE; state_d = S_LOOK;  end
      S_LOOK:  begin cmd_o.op = lsp_pkg::OP_LOOK;  state_d = S_MS;    end
      S_MS:    begin cmd_o.op = lsp_pkg::OP_MS;    state_d = S_MC;    end
      S_MC:    begin cmd_o.op = lsp_pkg::OP_MC;    state_d = S_ERR;   end
      S_ERR:   begin cmd_o.op = lsp_pkg::OP_ERR;   state_d = S_EMU;   end
      S_EMU:   begin cmd_o.op = lsp_pkg::OP_EMU;   state_d = S_ES;    end
      S_ES:    begin cmd_o.op = lsp_pkg::OP_ES;    state_d = S_EC;    end
      S_EC:    begin cmd_o.op = lsp_pkg::OP_EC;    state_d = S_TSMU;  end
      S_TSMU:  begin cmd_o.op = lsp_pkg::OP_TSMU;  state_d = S_TCMU;  end
      S_TCMU:  begin cmd_o.op = lsp_pkg::OP_TCMU;  state_d = S_UPDC;  end
      S_UPDC: begin
        cmd_o.op = lsp_pkg::OP_UPDC;
        state_d  = status_i.track_mode ? S_PII : S_SQS;
      end
      S_PII:   begin cmd_o.op = lsp_pkg::OP_PII;   state_d = S_PIP;   end
      S_PIP:   begin cmd_o.op = lsp_pkg::OP_PIP;   state_d = S_PIO;   end
      S_PIO:   begin cmd_o.op = lsp_pkg::OP_PIO;   state_d = S_DONE;  end
      S_SQS:   begin cmd_o.op = lsp_pkg::OP_SQS;   state_d = S_SQC;   end
      S_SQC:   begin cmd_o.op = lsp_pkg::OP_SQC;   state_d = S_SQSUM; end
      S_SQSUM: begin
        cmd_o.op = lsp_pkg::OP_SQSUM;
        cnt_d    = '1;
        state_d  = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.op = lsp_pkg::OP_ROOT;
        cnt_d    = cnt_q - 5'd1;
        if (cnt_q == 5'd0) state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = lsp_pkg::OP_DONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== sv/lsp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_dp
// Datapath: config registers, shared multiplier, coefficients, PI, root.
// ----------------------------------------------------------------------------
module lsp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [15:0] sample_i,
  input  lsp_pkg::cmd_t      cmd_i,
  output lsp_pkg::status_t   status_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic signed [31:0] offset_est_o,
  output logic signed [31:0] sine_coef_o,
  output logic signed [31:0] cosine_coef_o,
  output logic signed [31:0] amplitude_o,
  output logic [31:0]        phase_step_now_o,
  output logic signed [31:0] regulator_out_o
);

  logic        mode_q;
  logic [31:0] base_q;
  logic [15:0] mu_q;
  logic [23:0] kp_q;
  logic [23:0] ki_q;
  logic [31:0] kc_q;

  logic signed [15:0] smp_q;
  logic [31:0]        phase_q;
  logic [31:0]        step_q;
  logic signed [15:0] s_q, c_q;
  logic signed [31:0] coef0_q, coef1_q, coef2_q;
  logic signed [31:0] e_q;
  logic signed [67:0] acc_q;
  logic signed [32:0] t1_q, t2_q;
  logic signed [31:0] prev_q, integ_q, pi_q;
  logic               ovf_q;
  logic [63:0]        sq_q, rv_q, res_q, bit_q;
  logic signed [67:0] p_q, p_d;
  logic signed [33:0] mul_a, mul_b;

  logic               out_valid_q;
  logic signed [31:0] off_oq, sin_oq, cos_oq, amp_oq, reg_oq;
  logic [31:0]        step_oq;

  logic signed [67:0] p_s15, p_s16, p_s24;
  logic [31:0]        step_new;
  logic [32:0]        ab, ac;
  logic [63:0]        trial;
  logic [31:0]        root_amp;

  assign p_s15 = p_q >>> 15;
  assign p_s16 = p_q >>> 16;
  assign p_s24 = p_q >>> 24;
  assign ab    = coef1_q[31] ? (33'd0 - {coef1_q[31], coef1_q}) : {1'b0, coef1_q};
  assign ac    = coef2_q[31] ? (33'd0 - {coef2_q[31], coef2_q}) : {1'b0, coef2_q};
  assign trial = res_q + bit_q;
  assign step_new = base_q + (mode_q ? p_s24[31:0] : 32'd0);
  assign root_amp = ovf_q ? lsp_pkg::AMP_LIM :
                    (res_q > {32'd0, lsp_pkg::AMP_LIM}) ? lsp_pkg::AMP_LIM : res_q[31:0];

  assign status_o.track_mode = mode_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    mul_a = 34'sd0;
    mul_b = 34'sd0;
    case (cmd_i.op)
      lsp_pkg::OP_CORR: begin mul_a = 34'(pi_q); mul_b = $signed({2'b00, kc_q}); end
      lsp_pkg::OP_MS:   begin mul_a = 34'(s_q);  mul_b = 34'(coef1_q); end
      lsp_pkg::OP_MC:   begin mul_a = 34'(c_q);  mul_b = 34'(coef2_q); end
      lsp_pkg::OP_EMU:  begin mul_a = 34'(e_q);  mul_b = $signed({18'd0, mu_q}); end
      lsp_pkg::OP_ES:   begin mul_a = 34'(e_q);  mul_b = 34'(s_q); end
      lsp_pkg::OP_EC:   begin mul_a = 34'(e_q);  mul_b = 34'(c_q); end
      lsp_pkg::OP_TSMU: begin mul_a = 34'(t1_q); mul_b = $signed({18'd0, mu_q}); end
      lsp_pkg::OP_TCMU: begin mul_a = 34'(t2_q); mul_b = $signed({18'd0, mu_q}); end
      lsp_pkg::OP_PII: begin
        mul_a = 34'($signed({coef2_q[31], coef2_q}) + $signed({prev_q[31], prev_q}));
        mul_b = $signed({10'd0, ki_q});
      end
      lsp_pkg::OP_PIP:  begin mul_a = 34'(coef2_q); mul_b = $signed({10'd0, kp_q}); end
      lsp_pkg::OP_SQS:  begin mul_a = $signed({1'b0, ab}); mul_b = $signed({1'b0, ab}); end
      lsp_pkg::OP_SQC:  begin mul_a = $signed({1'b0, ac}); mul_b = $signed({1'b0, ac}); end
      default: ;
    endcase
    p_d = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      base_q <= 32'd0;
      mu_q   <= 16'd0;
      kp_q   <= lsp_pkg::PROP_GAIN_RST;
      ki_q   <= 24'd0;
      kc_q   <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lsp_pkg::REG_TRACK_MODE: mode_q <= cfg_data_i[0];
        lsp_pkg::REG_BASE_STEP:  base_q <= cfg_data_i;
        lsp_pkg::REG_STEP_SIZE:  mu_q   <= cfg_data_i[15:0];
        lsp_pkg::REG_PROP_GAIN:  kp_q   <= cfg_data_i[23:0];
        lsp_pkg::REG_INTEG_COEF: ki_q   <= cfg_data_i[23:0];
        lsp_pkg::REG_CORR_GAIN:  kc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 32'd0;
      coef0_q <= 32'sd0;
      coef1_q <= 32'sd0;
      coef2_q <= 32'sd0;
      prev_q  <= 32'sd0;
      integ_q <= 32'sd0;
      pi_q    <= 32'sd0;
    end else begin
      case (cmd_i.op)
        lsp_pkg::OP_PHASE: phase_q <= phase_q + step_new;
        lsp_pkg::OP_ES:    coef0_q <= lsp_pkg::sat32(68'(coef0_q) - p_s16);
        lsp_pkg::OP_TCMU:  coef1_q <= lsp_pkg::sat32(68'(coef1_q) - p_s16);
        lsp_pkg::OP_UPDC:  coef2_q <= lsp_pkg::sat32(68'(coef2_q) - p_s16);
        lsp_pkg::OP_PIP:   integ_q <= lsp_pkg::sat32(p_s24 + 68'(integ_q));
        lsp_pkg::OP_PIO: begin
          pi_q   <= lsp_pkg::sat32(68'(integ_q) + p_s16);
          prev_q <= coef2_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    case (cmd_i.op)
      lsp_pkg::OP_LOAD:  smp_q  <= sample_i;
      lsp_pkg::OP_PHASE: step_q <= step_new;
      lsp_pkg::OP_LOOK: begin
        s_q <= lsp_pkg::sine_at(phase_q[31:32-lsp_pkg::IDX_W]);
        c_q <= lsp_pkg::sine_at(phase_q[31:32-lsp_pkg::IDX_W]
                                + lsp_pkg::IDX_W'(lsp_pkg::QUARTER));
      end
      lsp_pkg::OP_MC:    acc_q <= 68'(coef0_q) + p_s15;
      lsp_pkg::OP_ERR:
        e_q <= lsp_pkg::sat32(acc_q + p_s15 - (68'(smp_q) <<< 9));
      lsp_pkg::OP_EC:    t1_q <= p_s15[32:0];
      lsp_pkg::OP_TSMU:  t2_q <= p_s15[32:0];
      lsp_pkg::OP_SQS:
        ovf_q <= (ab >= {1'b0, lsp_pkg::AMP_LIM}) || (ac >= {1'b0, lsp_pkg::AMP_LIM});
      lsp_pkg::OP_SQC:   sq_q <= p_q[63:0];
      lsp_pkg::OP_SQSUM: begin
        rv_q  <= sq_q + p_q[63:0];
        res_q <= 64'd0;
        bit_q <= 64'd1 << 62;
      end
      lsp_pkg::OP_ROOT: begin
        if (rv_q >= trial) begin
          rv_q  <= rv_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      lsp_pkg::OP_DONE: begin
        off_oq  <= coef0_q;
        sin_oq  <= coef1_q;
        cos_oq  <= coef2_q;
        amp_oq  <= mode_q ? coef1_q : $signed(root_amp);
        step_oq <= step_q;
        reg_oq  <= pi_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == lsp_pkg::OP_DONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign offset_est_o     = off_oq;
  assign sine_coef_o      = sin_oq;
  assign cosine_coef_o    = cos_oq;
  assign amplitude_o      = amp_oq;
  assign phase_step_now_o = step_oq;
  assign regulator_out_o  = reg_oq;

endmodule

// ===== sv/lms_sine_fit_with_pll_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_sine_fit_with_pll_top
// LMS sine fit with optional PI phase-locked tracking.
// ----------------------------------------------------------------------------
// Input channel: one Q1.15 sample word per transfer (in_valid_i/in_stall_o).
// Output channel: one result word per sample (out_valid_o/out_stall_i):
// offset, sine and cosine coefficients, amplitude, phase step, PI output.
// Config channel: cfg_valid_i/cfg_ready_o with register index and data;
// always ready, write only while no sample is in flight.
// One sample is in work at a time, and the input reopens in the same cycle
// as the result lands, so a new sample is not taken before then. The step
// sequence is set by one shared 34x34 multiplier used for every product,
// and in fixed mode by the 32-step bit-serial square root.
// The result register frees the datapath: a stalled result holds, and the
// next sample is processed but waits for the register before it lands.
// Reset clears phase, coefficients and PI state, loads register defaults
// (proportional gain 15.0) and empties the result register.
// ----------------------------------------------------------------------------
module lms_sine_fit_with_pll_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] offset_est_o,
  output logic signed [31:0] sine_coef_o,
  output logic signed [31:0] cosine_coef_o,
  output logic signed [31:0] amplitude_o,
  output logic [31:0]        phase_step_now_o,
  output logic signed [31:0] regulator_out_o
);

  lsp_pkg::cmd_t    cmd;
  lsp_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  lsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lsp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .sample_i         (sample_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .offset_est_o     (offset_est_o),
    .sine_coef_o      (sine_coef_o),
    .cosine_coef_o    (cosine_coef_o),
    .amplitude_o      (amplitude_o),
    .phase_step_now_o (phase_step_now_o),
    .regulator_out_o  (regulator_out_o)
  );

endmodule
